FILE: rtl/core/fdct_pkg.sv
// shared types, constants and sequencer program of the 16-point fast dct
`timescale 1ns / 1ps
package fdct_pkg;

	localparam int SAMPLE_W = 24;
	localparam int OUT_W    = 32;
	localparam int FRAC_W   = 20;
	localparam int COEF_W   = 23;
	localparam int ACC_W    = 40;
	localparam int HI_W     = ACC_W - 1 - FRAC_W;
	localparam int NPTS     = 16;
	localparam int IDX_W    = 4;
	localparam int ADDR_W   = 7;
	localparam int RAM_D    = 128;
	localparam int PC_W     = 7;
	localparam int LAST_PC  = 80;
	localparam int QDEPTH   = 4;
	localparam longint unsigned POW5_14 = 64'd6103515625;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [IDX_W-1:0]           idx;
	} smp_t;

	typedef enum logic {
		OP_ADD,
		OP_MSUB
	} op_code_t;

	typedef struct packed {
		op_code_t          code;
		logic [ADDR_W-1:0] dst;
		logic [ADDR_W-1:0] a;
		logic [ADDR_W-1:0] b;
		logic [3:0]        k;
	} op_t;

	// decimal in 1e-14 units to fixed point, nearest, ties up
	function automatic logic [COEF_W-1:0] to_fixed(input longint unsigned d);
		longint unsigned n;
		n = d << (FRAC_W - 14);
		return COEF_W'((2 * n + POW5_14) / (2 * POW5_14));
	endfunction

	function automatic logic [COEF_W-1:0] coef_f(input logic [3:0] k);
		logic [COEF_W-1:0] c;
		case (k)
			4'd0:    c = to_fixed(64'd50241928618816);
			4'd1:    c = to_fixed(64'd52249861493969);
			4'd2:    c = to_fixed(64'd56694403481636);
			4'd3:    c = to_fixed(64'd64682178335999);
			4'd4:    c = to_fixed(64'd78815462345125);
			4'd5:    c = to_fixed(64'd106067768599035);
			4'd6:    c = to_fixed(64'd172244709823833);
			4'd7:    c = to_fixed(64'd510114861868916);
			4'd8:    c = to_fixed(64'd50979557910416);
			4'd9:    c = to_fixed(64'd60134488693505);
			4'd10:   c = to_fixed(64'd89997622313642);
			4'd11:   c = to_fixed(64'd256291544774151);
			4'd12:   c = to_fixed(64'd54119610014620);
			4'd13:   c = to_fixed(64'd130656296487638);
			default: c = to_fixed(64'd70710678118655);
		endcase
		return c;
	endfunction

	function automatic op_t mk(input op_code_t c, input int d, input int a, input int b,
		input int k);
		op_t o;
		o.code = c;
		o.dst  = ADDR_W'(d);
		o.a    = ADDR_W'(a);
		o.b    = ADDR_W'(b);
		o.k    = 4'(k);
		return o;
	endfunction

	// 4-point kernel, inputs at ib..ib+3, scratch and results at bb..bb+8
	function automatic op_t dct4_f(input int j, input int ib, input int bb);
		op_t o;
		case (j)
			0:       o = mk(OP_ADD,  bb,     ib,     ib + 3, 0);
			1:       o = mk(OP_ADD,  bb + 1, ib + 1, ib + 2, 0);
			2:       o = mk(OP_MSUB, bb + 2, ib,     ib + 3, 12);
			3:       o = mk(OP_MSUB, bb + 3, ib + 1, ib + 2, 13);
			4:       o = mk(OP_MSUB, bb + 4, bb + 2, bb + 3, 14);
			5:       o = mk(OP_ADD,  bb + 5, bb,     bb + 1, 0);
			6:       o = mk(OP_MSUB, bb + 6, bb,     bb + 1, 14);
			7:       o = mk(OP_ADD,  bb + 7, bb + 2, bb + 3, 0);
			default: o = mk(OP_ADD,  bb + 8, bb + 7, bb + 4, 0);
		endcase
		return o;
	endfunction

	// first butterfly of an 8-point kernel on xb..xb+7
	function automatic op_t dct8_f(input int j, input int xb, input int sb, input int db);
		int i;
		i = j >> 1;
		if ((j & 1) == 0)
			return mk(OP_ADD, sb + i, xb + i, xb + 7 - i, 0);
		return mk(OP_MSUB, db + i, xb + i, xb + 7 - i, 8 + i);
	endfunction

	function automatic op_t prog_f(input logic [PC_W-1:0] pc);
		int p;
		int i;
		op_t o;
		p = int'(pc);
		i = p >> 1;
		if (p < 16) begin
			if ((p & 1) == 0)
				o = mk(OP_ADD, 16 + i, i, 15 - i, 0);
			else
				o = mk(OP_MSUB, 24 + i, i, 15 - i, i);
		end else if (p < 24) begin
			o = dct8_f(p - 16, 16, 32, 36);
		end else if (p < 33) begin
			o = dct4_f(p - 24, 32, 40);
		end else if (p < 42) begin
			o = dct4_f(p - 33, 36, 49);
		end else if (p < 45) begin
			case (p - 42)
				0:       o = mk(OP_ADD, 58, 54, 57, 0);
				1:       o = mk(OP_ADD, 59, 57, 55, 0);
				default: o = mk(OP_ADD, 60, 55, 53, 0);
			endcase
		end else if (p < 53) begin
			o = dct8_f(p - 45, 24, 96, 100);
		end else if (p < 62) begin
			o = dct4_f(p - 53, 96, 104);
		end else if (p < 71) begin
			o = dct4_f(p - 62, 100, 113);
		end else if (p < 74) begin
			case (p - 71)
				0:       o = mk(OP_ADD, 122, 118, 121, 0);
				1:       o = mk(OP_ADD, 123, 121, 119, 0);
				default: o = mk(OP_ADD, 124, 119, 117, 0);
			endcase
		end else begin
			case (p - 74)
				0:       o = mk(OP_ADD, 125, 109, 122, 0);
				1:       o = mk(OP_ADD, 126, 122, 112, 0);
				2:       o = mk(OP_ADD, 127, 112, 123, 0);
				3:       o = mk(OP_ADD, 64,  123, 110, 0);
				4:       o = mk(OP_ADD, 65,  110, 124, 0);
				5:       o = mk(OP_ADD, 66,  124, 108, 0);
				default: o = mk(OP_ADD, 67,  108, 117, 0);
			endcase
		end
		return o;
	endfunction

	// where coefficient k sits in the working store
	function automatic logic [ADDR_W-1:0] out_addr_f(input logic [IDX_W-1:0] k);
		logic [ADDR_W-1:0] a;
		case (k)
			4'd0:    a = 7'd45;
			4'd1:    a = 7'd64;
			4'd2:    a = 7'd59;
			4'd3:    a = 7'd127;
			4'd4:    a = 7'd48;
			4'd5:    a = 7'd126;
			4'd6:    a = 7'd58;
			4'd7:    a = 7'd125;
			4'd8:    a = 7'd46;
			4'd9:    a = 7'd65;
			4'd10:   a = 7'd60;
			4'd11:   a = 7'd66;
			4'd12:   a = 7'd44;
			4'd13:   a = 7'd67;
			4'd14:   a = 7'd53;
			default: a = 7'd117;
		endcase
		return a;
	endfunction

endpackage

FILE: rtl/core/fast_dct_16_point.sv
// top level of the 16-point fast dct
//
//  channel | ports                                 | transfer
//  --------+---------------------------------------+------------------------------
//  input   | start, busy, sample                   | start high and busy low
//  result  | coef_valid, coefficient, coef_index,  | every cycle coef_valid is high
//          | last                                  |
//
// samples are taken one a cycle while the four-entry queue has room.
// the sixteenth sample starts the program: 49 add steps (read, oper, write)
// and 32 multiply steps (read, oper, mlo, mhi, rnd, write), run one at a time,
// then 16 coefficients on consecutive cycles via the ram and output registers.
// while the program runs, samples wait in the queue; busy is high while it is full.
// reset clears counters, queue and sequencer; the receiver cannot stall.
`timescale 1ns / 1ps
module fast_dct_16_point (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [fdct_pkg::SAMPLE_W-1:0] sample,
	output logic                                coef_valid,
	output logic signed [fdct_pkg::OUT_W-1:0]   coefficient,
	output logic [fdct_pkg::IDX_W-1:0]          coef_index,
	output logic                                last
);
	import fdct_pkg::*;

	logic push;
	logic pop;
	logic full;
	logic empty;
	smp_t wentry;
	smp_t rentry;

	assign busy = full;

	fdct_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.full   (full),
		.sample (sample),
		.push   (push),
		.entry  (wentry)
	);

	fdct_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wentry (wentry),
		.pop    (pop),
		.rentry (rentry),
		.full   (full),
		.empty  (empty)
	);

	fdct_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (empty),
		.rentry      (rentry),
		.pop         (pop),
		.coef_valid  (coef_valid),
		.coefficient (coefficient),
		.coef_index  (coef_index),
		.last        (last)
	);

endmodule

FILE: rtl/core/fdct_ram.sv
// generic ram, one write port and two registered read ports
`timescale 1ns / 1ps
module fdct_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr_a,
	input  logic [$clog2(D)-1:0] raddr_b,
	output logic [W-1:0]         rdata_a,
	output logic [W-1:0]         rdata_b
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

FILE: rtl/core/fdct_front.sv
// front end: takes samples and tags each with its place in the block
`timescale 1ns / 1ps
module fdct_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic                                  full,
	input  logic signed [fdct_pkg::SAMPLE_W-1:0]  sample,
	output logic                                  push,
	output fdct_pkg::smp_t                        entry
);
	import fdct_pkg::*;

	logic [IDX_W-1:0] fill_q;

	assign push         = start && !full;
	assign entry.sample = sample;
	assign entry.idx    = fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fill_q <= '0;
		else if (push)
			fill_q <= fill_q + 1'b1;
	end

endmodule

FILE: rtl/core/fdct_queue.sv
// short queue between front end and sequencer
`timescale 1ns / 1ps
module fdct_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fdct_pkg::smp_t wentry,
	input  logic           pop,
	output fdct_pkg::smp_t rentry,
	output logic           full,
	output logic           empty
);
	import fdct_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	smp_t          slot_q [QDEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0]   cnt_q;

	assign full   = cnt_q == (PW + 1)'(QDEPTH);
	assign empty  = cnt_q == '0;
	assign rentry = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= wentry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PW + 1)'(push) - (PW + 1)'(pop);
		end
	end

endmodule

FILE: rtl/core/fdct_back.sv
// sequencer: loads a block, runs the butterfly program, emits coefficients
`timescale 1ns / 1ps
module fdct_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                empty,
	input  fdct_pkg::smp_t                      rentry,
	output logic                                pop,
	output logic                                coef_valid,
	output logic signed [fdct_pkg::OUT_W-1:0]   coefficient,
	output logic [fdct_pkg::IDX_W-1:0]          coef_index,
	output logic                                last
);
	import fdct_pkg::*;

	typedef enum logic [7:0] {
		S_LOAD  = 8'b00000001,
		S_READ  = 8'b00000010,
		S_OPER  = 8'b00000100,
		S_MLO   = 8'b00001000,
		S_MHI   = 8'b00010000,
		S_RND   = 8'b00100000,
		S_WRITE = 8'b01000000,
		S_EMIT  = 8'b10000000
	} state_t;

	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
	localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
	localparam logic [FRAC_W+COEF_W:0]  HALF   = (FRAC_W + COEF_W + 1)'(1) << (FRAC_W - 1);

	state_t                    state_q;
	logic [PC_W-1:0]           pc_q;
	logic [IDX_W-1:0]          k_q;
	logic                      em_v_s1;
	logic [IDX_W-1:0]          em_k_s1;
	logic signed [ACC_W-1:0]   r_q;
	logic [FRAC_W+COEF_W-1:0]  pl_q;
	logic [HI_W+COEF_W-1:0]    ph_q;
	logic                      cv_q;
	logic signed [OUT_W-1:0]   coef_q;
	logic [IDX_W-1:0]          cidx_q;
	logic                      last_q;

	op_t                       op;
	logic [COEF_W-1:0]         cval;
	logic signed [ACC_W-1:0]   rd_a;
	logic signed [ACC_W-1:0]   rd_b;
	logic [ACC_W-1:0]          mag;
	logic [FRAC_W+COEF_W:0]    pl_rnd;
	logic [ACC_W-1:0]          qmag;
	logic                      we;
	logic [ADDR_W-1:0]         waddr;
	logic [ACC_W-1:0]          wdata;
	logic [ADDR_W-1:0]         raddr_a;

	assign op     = prog_f(pc_q);
	assign cval   = coef_f(op.k);
	assign pop    = (state_q == S_LOAD) && !empty;
	assign mag    = r_q[ACC_W-1] ? ACC_W'(-r_q) : r_q;
	assign pl_rnd = {1'b0, pl_q} + HALF;
	assign qmag   = ACC_W'(ph_q) + ACC_W'(pl_rnd[FRAC_W+COEF_W:FRAC_W]);

	assign we      = pop || (state_q == S_WRITE);
	assign waddr   = pop ? ADDR_W'(rentry.idx) : op.dst;
	assign wdata   = pop ? ACC_W'(rentry.sample) : r_q;
	assign raddr_a = (state_q == S_EMIT) ? out_addr_f(k_q) : op.a;

	fdct_ram #(
		.W (ACC_W),
		.D (RAM_D)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (op.b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			pc_q    <= '0;
			k_q     <= '0;
			em_v_s1 <= 1'b0;
			cv_q    <= 1'b0;
		end else begin
			em_v_s1 <= 1'b0;
			cv_q    <= em_v_s1;
			case (state_q)
				S_LOAD: begin
					if (pop && rentry.idx == IDX_W'(NPTS - 1)) begin
						pc_q    <= '0;
						state_q <= S_READ;
					end
				end
				S_READ:  state_q <= S_OPER;
				S_OPER:  state_q <= (op.code == OP_MSUB) ? S_MLO : S_WRITE;
				S_MLO:   state_q <= S_MHI;
				S_MHI:   state_q <= S_RND;
				S_RND:   state_q <= S_WRITE;
				S_WRITE: begin
					if (pc_q == PC_W'(LAST_PC)) begin
						k_q     <= '0;
						state_q <= S_EMIT;
					end else begin
						pc_q    <= pc_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_EMIT: begin
					em_v_s1 <= 1'b1;
					k_q     <= k_q + 1'b1;
					if (k_q == IDX_W'(NPTS - 1))
						state_q <= S_LOAD;
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		em_k_s1 <= k_q;
		case (state_q)
			S_OPER:  r_q  <= (op.code == OP_ADD) ? rd_a + rd_b : rd_a - rd_b;
			S_MLO:   pl_q <= mag[FRAC_W-1:0] * cval;
			S_MHI:   ph_q <= mag[ACC_W-2:FRAC_W] * cval;
			S_RND:   r_q  <= r_q[ACC_W-1] ? -qmag : qmag;
			default: ;
		endcase
		if (em_v_s1) begin
			if (rd_a > SAT_HI)
				coef_q <= OUT_W'(SAT_HI);
			else if (rd_a < SAT_LO)
				coef_q <= OUT_W'(SAT_LO);
			else
				coef_q <= OUT_W'(rd_a);
			cidx_q <= em_k_s1;
			last_q <= em_k_s1 == IDX_W'(NPTS - 1);
		end
	end

	assign coef_valid  = cv_q;
	assign coefficient = coef_q;
	assign coef_index  = cidx_q;
	assign last        = last_q;

	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		coef_valid && !last |=> coef_valid && coef_index == IDX_W'($past(coef_index) + 1'b1))
		else $error("coefficient index did not advance");
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(coef_valid) |-> coef_index == '0)
		else $error("burst did not start at coefficient zero");
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		coef_valid && last |=> !coef_valid)
		else $error("strobe continued past last coefficient");
	a_prog: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WRITE && pc_q == PC_W'(LAST_PC) |=> state_q == S_EMIT)
		else $error("program end did not start emission");

endmodule

FILE: tb/sv/fast_dct_16_point_tb.sv
// self-checking testbench of the 16-point fast dct against a fixed-point butterfly predictor
`timescale 1ns / 1ps
module fast_dct_16_point_tb;
	import fdct_pkg::*;

	localparam longint ILIM = 64'sd1 << 61;
	localparam longint unsigned P5 = 64'd6103515625;

	typedef struct {
		logic signed [OUT_W-1:0] coef;
		logic [IDX_W-1:0]        idx;
		logic                    lst;
	} coef_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] smp;
		bit                         typed;
		longint                     dc;
	} row_t;

	logic clk, arst_n, start, busy, coef_valid, last;
	logic signed [SAMPLE_W-1:0] sample;
	logic signed [OUT_W-1:0]    coefficient;
	logic [IDX_W-1:0]           coef_index;

	coef_t  coef_q[$];
	longint smp_buf[16];
	int     fill;
	int     errors;
	bit     stim_done;
	row_t   dir_rows[$];

	// constants in 1e-14 units: first stage, second stage, third stage, cos(pi/4)
	longint unsigned c1[8] = '{64'd50241928618816, 64'd52249861493969, 64'd56694403481636,
		64'd64682178335999, 64'd78815462345125, 64'd106067768599035,
		64'd172244709823833, 64'd510114861868916};
	longint unsigned c2[4] = '{64'd50979557910416, 64'd60134488693505,
		64'd89997622313642, 64'd256291544774151};
	longint unsigned c3[2] = '{64'd54119610014620, 64'd130656296487638};
	longint unsigned c4 = 64'd70710678118655;

	fast_dct_16_point DUT (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("fast_dct_16_point verification failed");
		$finish;
	end

	function automatic longint clip61(input longint v);
		if (v > ILIM) return ILIM;
		if (v < -ILIM) return -ILIM;
		return v;
	endfunction

	function automatic longint mul_round(input longint x, input longint unsigned d);
		longint unsigned c, m, q;
		c = ((d << (FRAC_W - 14)) * 2 + P5) / (2 * P5);
		m = (x < 0) ? longint'(-x) : x;
		q = (m * c + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
		if (q > ILIM) q = ILIM;
		return (x < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic void dct4_calc(input longint a[4], output longint g[4]);
		longint h0, h1, t0, t1, r1;
		h0 = clip61(a[0] + a[3]);
		h1 = clip61(a[1] + a[2]);
		t0 = mul_round(clip61(a[0] - a[3]), c3[0]);
		t1 = mul_round(clip61(a[1] - a[2]), c3[1]);
		r1 = mul_round(clip61(t0 - t1), c4);
		g[0] = clip61(h0 + h1);
		g[2] = mul_round(clip61(h0 - h1), c4);
		g[1] = clip61(clip61(t0 + t1) + r1);
		g[3] = r1;
	endfunction

	function automatic void dct8_calc(input longint x[8], output longint y[8]);
		longint s[4], d[4], g[4], h[4];
		for (int i = 0; i < 4; i++) begin
			s[i] = clip61(x[i] + x[7-i]);
			d[i] = mul_round(clip61(x[i] - x[7-i]), c2[i]);
		end
		dct4_calc(s, g);
		dct4_calc(d, h);
		y[0] = g[0]; y[2] = g[1]; y[4] = g[2]; y[6] = g[3];
		y[1] = clip61(h[0] + h[1]);
		y[3] = clip61(h[1] + h[2]);
		y[5] = clip61(h[2] + h[3]);
		y[7] = h[3];
	endfunction

	// stores a sample; on the sixteenth, returns the 16 coefficients in k order
	function automatic bit dct_block(input logic signed [SAMPLE_W-1:0] s,
		output longint co[16]);
		longint a[8], b[8], y[8], z[8];
		smp_buf[fill] = s;
		if (fill != 15) begin
			fill++;
			return 0;
		end
		fill = 0;
		for (int i = 0; i < 8; i++) begin
			a[i] = smp_buf[i] + smp_buf[15-i];
			b[i] = mul_round(smp_buf[i] - smp_buf[15-i], c1[i]);
		end
		dct8_calc(a, y);
		dct8_calc(b, z);
		co[0] = y[0]; co[8] = y[4]; co[12] = y[6]; co[6] = y[1];
		co[4] = y[2]; co[2] = y[3]; co[10] = y[5]; co[14] = y[7];
		co[7] = clip61(z[0] + z[1]);
		co[5] = clip61(z[1] + z[2]);
		co[3] = clip61(z[2] + z[3]);
		co[1] = clip61(z[3] + z[4]);
		co[9] = clip61(z[4] + z[5]);
		co[11] = clip61(z[5] + z[6]);
		co[13] = clip61(z[6] + z[7]);
		co[15] = z[7];
		for (int i = 0; i < 16; i++) begin
			if (co[i] > 64'sd2147483647) co[i] = 64'sd2147483647;
			if (co[i] < -64'sd2147483648) co[i] = -64'sd2147483648;
		end
		return 1;
	endfunction

	task automatic push_coefs(input longint co[16]);
		coef_t e;
		for (int i = 0; i < 16; i++) begin
			e.coef = co[i][OUT_W-1:0];
			e.idx  = IDX_W'(i);
			e.lst  = (i == 15);
			coef_q.push_back(e);
		end
	endtask

	task automatic send_sample(input row_t r, input int gap);
		longint co[16];
		bit b;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start  <= 1'b1;
		sample <= r.smp;
		forever begin
			@(negedge clk);
			b = busy;
			@(posedge clk);
			if (!b) break;
		end
		if (dct_block(r.smp, co)) begin
			// flat block: only the dc term survives
			if (r.typed) begin
				co[0] = r.dc;
				for (int i = 1; i < 16; i++) co[i] = 0;
			end
			push_coefs(co);
		end
	endtask

	always @(negedge clk) begin
		coef_t e;
		if (arst_n && coef_valid) begin
			if (coef_q.size() == 0) begin
				$error("coefficient transfer with none expected, k=%0d", coef_index);
				errors++;
			end else begin
				e = coef_q.pop_front();
				if (coefficient !== e.coef) begin
					$error("coefficient: expected %0d, got %0d", e.coef, coefficient);
					errors++;
				end
				if (coef_index !== e.idx) begin
					$error("coef_index: expected %0d, got %0d", e.idx, coef_index);
					errors++;
				end
				if (last !== e.lst) begin
					$error("last: expected %0d, got %0d", e.lst, last);
					errors++;
				end
			end
		end
	end

	initial begin
		row_t r;
		int   gap_max;
		errors = 0;
		fill = 0;
		stim_done = 0;
		arst_n = 1'b0;
		start  = 1'b0;
		sample = '0;
		// directed: flat maximum block, then alternating one and most negative
		for (int i = 0; i < 16; i++)
			dir_rows.push_back('{24'sh7FFFFF, i == 15, 64'sd134217712});
		for (int i = 0; i < 9; i++)
			dir_rows.push_back('{(i % 2) ? 24'sh800000 : 24'sh000001, 0, 0});
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i])
			send_sample(dir_rows[i], (i < 8) ? 0 : $urandom_range(0, 8));
		for (int i = 0; i < 280; i++) begin
			if (i % 64 == 0) gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
			r.typed = 0;
			r.dc = 0;
			case ($urandom_range(0, 9))
				0:       r.smp = 24'sh7FFFFF;
				1:       r.smp = 24'sh800000;
				2:       r.smp = SAMPLE_W'($urandom_range(0, 255) - 128);
				default: r.smp = SAMPLE_W'($urandom);
			endcase
			send_sample(r, $urandom_range(0, gap_max));
		end
		// finish the open block so every sample yields a check
		while (fill != 0) begin
			r.smp = SAMPLE_W'($urandom);
			send_sample(r, $urandom_range(0, 8));
		end
		start <= 1'b0;
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		wait (coef_q.size() == 0);
		repeat (400) @(posedge clk);
		if (errors == 0 && coef_q.size() == 0)
			$display("fast_dct_16_point verification clean");
		else
			$display("fast_dct_16_point verification failed");
		$finish;
	end

endmodule
